// File: sv/prescaled_timer_with_reload_assert.svh
// assertion macros for the prescaled timer
// used by the controller; expects clk and arst_n in the including scope
`ifndef PRESCALED_TIMER_WITH_RELOAD_ASSERT_SVH
`define PRESCALED_TIMER_WITH_RELOAD_ASSERT_SVH

`ifndef SYNTHESIS
`define PTR_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("timer assertion failed");
`define PTR_NEVER(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error("timer forbidden condition seen");
`else
`define PTR_ASSERT(lbl, prop)
`define PTR_NEVER(lbl, cond)
`endif

`endif

// File: sv/ptr_pkg.sv
// shared types, codes and the period lookup for the prescaled timer
// no dependencies
`timescale 1ns / 1ps

package ptr_pkg;

	localparam logic [1:0] ACT_TICK  = 2'd0;
	localparam logic [1:0] ACT_READ  = 2'd1;
	localparam logic [1:0] ACT_WRITE = 2'd2;

	localparam logic [1:0] REG_DIV  = 2'd0;
	localparam logic [1:0] REG_CNT  = 2'd1;
	localparam logic [1:0] REG_MOD  = 2'd2;
	localparam logic [1:0] REG_CTRL = 2'd3;

	localparam int PRESCALE_W = 10;
	localparam int PERIOD_W   = PRESCALE_W + 1;

	typedef struct packed {
		logic [1:0] action;
		logic [1:0] reg_index;
		logic [7:0] write_data;
		logic [7:0] tick_count;
	} item_t;

	typedef struct packed {
		logic [7:0] read_data;
		logic       timer_irq;
	} result_t;

	typedef struct packed {
		logic accept;
		logic step;
		logic push;
	} cmd_t;

	typedef struct packed {
		logic is_tick;
		logic zero_count;
		logic last_step;
	} sts_t;

	function automatic logic [PERIOD_W-1:0] period_of(input logic [1:0] speed);
		logic [PERIOD_W-1:0] p;
		begin
			unique case (speed)
				2'd0: p = PERIOD_W'(1024);
				2'd1: p = PERIOD_W'(16);
				2'd2: p = PERIOD_W'(64);
				default: p = PERIOD_W'(256);
			endcase
			return p;
		end
	endfunction

endpackage

// File: sv/prescaled_timer_with_reload.sv
// Prescaled timer with reload: divider, counter, modulo and control registers.
// Input channel: in_valid/in_stall with in_data (action, reg_index, write_data,
// tick_count). A tick transaction advances the timer by tick_count machine
// cycles, a read returns one register, a write updates one register.
// Output channel: out_valid/out_stall with out_data; exactly one result per
// transaction, read_data on reads, timer_irq on ticks that overflowed.
// A read, a write or a zero-length tick goes from acceptance straight to the
// done state; a tick first runs its machine cycles, one clock per machine cycle
// stepped by the controller through the shared counter datapath.
// Next transaction is taken in the cycle after the result moves to the output
// register, so no transaction is taken while one is still in progress.
// A stalled receiver holds out_data; the block finishes the next transaction
// and waits until the output register frees.
// Reset clears all timer registers to zero (period 1024, timer stopped).
// Depends on ptr_pkg, ptr_ctrl and ptr_dpath.
`timescale 1ns / 1ps

module prescaled_timer_with_reload (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  ptr_pkg::item_t   in_data,
	output logic             out_valid,
	input  logic             out_stall,
	output ptr_pkg::result_t out_data
);
	import ptr_pkg::*;

	cmd_t cmd;
	sts_t sts;

	ptr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	ptr_dpath u_dpath (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (in_data),
		.cmd    (cmd),
		.sts    (sts),
		.result (out_data)
	);

endmodule

// File: sv/ptr_dpath.sv
// timer datapath: divider, counter, prescalers, registers and result staging
// depends on ptr_pkg
`timescale 1ns / 1ps

module ptr_dpath (
	input  logic            clk,
	input  logic            arst_n,
	input  ptr_pkg::item_t  item,
	input  ptr_pkg::cmd_t   cmd,
	output ptr_pkg::sts_t   sts,
	output ptr_pkg::result_t result
);
	import ptr_pkg::*;

	logic [7:0]            div_value_q;
	logic [7:0]            div_prescale_q;
	logic [7:0]            count_value_q;
	logic [7:0]            reload_value_q;
	logic [1:0]            speed_q;
	logic                  enabled_q;
	logic [PRESCALE_W-1:0] count_prescale_q;
	logic [7:0]            remain_q;
	logic [7:0]            rd_q;
	logic                  irq_q;
	result_t               out_q;

	logic [PERIOD_W-1:0] pre_next;
	logic                cnt_step;
	logic [7:0]          rd_mux;

	assign pre_next = {1'b0, count_prescale_q} + PERIOD_W'(1);
	assign cnt_step = enabled_q && (pre_next >= period_of(speed_q));

	always_comb begin
		unique case (item.reg_index)
			REG_DIV: rd_mux = div_value_q;
			REG_CNT: rd_mux = count_value_q;
			REG_MOD: rd_mux = reload_value_q;
			default: rd_mux = {5'b0, enabled_q, speed_q};
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_value_q      <= '0;
			div_prescale_q   <= '0;
			count_value_q    <= '0;
			reload_value_q   <= '0;
			speed_q          <= '0;
			enabled_q        <= 1'b0;
			count_prescale_q <= '0;
		end else if (cmd.accept) begin
			if (item.action == ACT_WRITE) begin
				unique case (item.reg_index)
					REG_DIV: div_value_q <= '0;
					REG_CNT: count_value_q <= item.write_data;
					REG_MOD: reload_value_q <= item.write_data;
					default: begin
						speed_q   <= item.write_data[1:0];
						enabled_q <= item.write_data[2];
					end
				endcase
			end
		end else if (cmd.step) begin
			div_prescale_q <= div_prescale_q + 8'd1;
			if (div_prescale_q == 8'hff)
				div_value_q <= div_value_q + 8'd1;
			if (enabled_q) begin
				if (cnt_step) begin
					count_prescale_q <= '0;
					if (count_value_q == 8'hff)
						count_value_q <= reload_value_q;
					else
						count_value_q <= count_value_q + 8'd1;
				end else begin
					count_prescale_q <= pre_next[PRESCALE_W-1:0];
				end
			end
		end
	end

	// per-transaction work registers
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			remain_q <= item.tick_count;
			irq_q    <= 1'b0;
			rd_q     <= (item.action == ACT_READ) ? rd_mux : 8'd0;
		end else if (cmd.step) begin
			remain_q <= remain_q - 8'd1;
			if (cnt_step && count_value_q == 8'hff)
				irq_q <= 1'b1;
		end
		if (cmd.push) begin
			out_q.read_data <= rd_q;
			out_q.timer_irq <= irq_q;
		end
	end

	assign sts.is_tick    = (item.action == ACT_TICK);
	assign sts.zero_count = (item.tick_count == 8'd0);
	assign sts.last_step  = (remain_q == 8'd1);
	assign result         = out_q;

endmodule

// File: sv/ptr_ctrl.sv
// timer controller: accepts transactions, sequences tick cycles, hands results out
// depends on ptr_pkg and prescaled_timer_with_reload_assert.svh
`timescale 1ns / 1ps

module ptr_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	output logic          out_valid,
	input  logic          out_stall,
	input  ptr_pkg::sts_t sts,
	output ptr_pkg::cmd_t cmd
);
	import ptr_pkg::*;
	`include "prescaled_timer_with_reload_assert.svh"

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_RUN  = 2'd1;
	localparam logic [1:0] ST_DONE = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       out_valid_q;

	assign in_stall   = (state_q != ST_IDLE);
	assign cmd.accept = in_valid && (state_q == ST_IDLE);
	assign cmd.step   = (state_q == ST_RUN);
	assign cmd.push   = (state_q == ST_DONE) && (!out_valid_q || !out_stall);
	assign out_valid  = out_valid_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (cmd.accept)
					state_d = (sts.is_tick && !sts.zero_count) ? ST_RUN : ST_DONE;
			end
			ST_RUN: begin
				if (sts.last_step)
					state_d = ST_DONE;
			end
			ST_DONE: begin
				if (cmd.push)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.push)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	`PTR_ASSERT(a_push_valid, cmd.push |=> out_valid_q)
	`PTR_ASSERT(a_run_done, (state_q == ST_RUN && sts.last_step) |=> state_q == ST_DONE)
	`PTR_ASSERT(a_direct_done, (cmd.accept && !sts.is_tick) |=> state_q == ST_DONE)
	`PTR_NEVER(a_step_accept, cmd.step && (cmd.accept || cmd.push))

endmodule
